// ----- sv/dxt_pkg.sv -----
// ----------------------------------------------------------------------------
// DXT block decoder package
// Shared types, endpoint widening tables and reciprocal constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dxt_pkg;

  localparam int TEXELS = 16;

  // format register codes
  localparam logic FMT_DXT1 = 1'b0;
  localparam logic FMT_DXT5 = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

  // reciprocals for truncating division by 3, 7 and 5
  // x/3 = (x*683)>>11 exact for x < 2048
  // x/7 = (x*4682)>>15 exact for x < 5461
  // x/5 = (x*6554)>>15 exact for x < 16384
  localparam logic [9:0]  RECIP3 = 10'd683;
  localparam logic [12:0] RECIP7 = 13'd4682;
  localparam logic [12:0] RECIP5 = 13'd6554;

  typedef logic [31:0][7:0] w5_tab_t;
  typedef logic [63:0][7:0] w6_tab_t;

  function automatic w5_tab_t build_w5();
    w5_tab_t t;
    for (int v = 0; v < 32; v++) begin
      t[v] = 8'((v * 255) / 31);
    end
    return t;
  endfunction

  function automatic w6_tab_t build_w6();
    w6_tab_t t;
    for (int v = 0; v < 64; v++) begin
      t[v] = 8'((v * 255) / 63);
    end
    return t;
  endfunction

  // 5-bit and 6-bit to 8-bit endpoint widening
  localparam w5_tab_t WIDEN5 = build_w5();
  localparam w6_tab_t WIDEN6 = build_w6();

  // decoded palettes and indices of one block
  typedef struct packed {
    logic [3:0][7:0]  red;
    logic [3:0][7:0]  green;
    logic [3:0][7:0]  blue;
    logic [7:0][7:0]  alpha;
    logic [15:0][1:0] cidx;
    logic [15:0][2:0] aidx;
    logic             dxt5;
  } pal_t;

  // emitter status back to the palette stage
  typedef struct packed {
    logic done;   // the block's last texel moves into the output register
  } emit_stat_t;

endpackage

`default_nettype wire

// ----- sv/dxt_color_lane.sv -----
// ----------------------------------------------------------------------------
// DXT colour lane
// Interpolated palette entries 2 and 3 for one colour channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt_color_lane (
  input  wire logic [7:0] e0,
  input  wire logic [7:0] e1,
  input  wire logic       four,
  output logic      [7:0] p2,
  output logic      [7:0] p3
);

  logic [9:0]  s2;
  logic [9:0]  s3;
  logic [19:0] m2;
  logic [19:0] m3;
  logic [8:0]  hsum;

  // weighted sums for the two thirds
  assign s2 = {1'b0, e0, 1'b0} + {2'b0, e1};
  assign s3 = {2'b0, e0} + {1'b0, e1, 1'b0};

  // divide by three through the reciprocal
  assign m2 = 20'(s2) * 20'(dxt_pkg::RECIP3);
  assign m3 = 20'(s3) * 20'(dxt_pkg::RECIP3);

  // midpoint for three-colour mode
  assign hsum = {1'b0, e0} + {1'b0, e1};

  assign p2 = four ? m2[18:11] : hsum[8:1];
  assign p3 = four ? m3[18:11] : 8'd0;

endmodule

`default_nettype wire

// ----- sv/dxt_alpha_lane.sv -----
// ----------------------------------------------------------------------------
// DXT alpha lane
// Eight-entry alpha palette from the two alpha endpoints.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt_alpha_lane (
  input  wire logic [7:0]      a0,
  input  wire logic [7:0]      a1,
  output logic      [7:0][7:0] pal
);

  logic gt;

  assign gt     = a0 > a1;
  assign pal[0] = a0;
  assign pal[1] = a1;

  // one independent entry per slot
  for (genvar i = 2; i < 8; i++) begin : g_ent
    localparam logic [3:0] WA7 = 4'(8 - i);
    localparam logic [3:0] WB7 = 4'(i - 1);
    logic [10:0] s7;
    logic [23:0] m7;

    assign s7 = 11'(WA7) * 11'(a0) + 11'(WB7) * 11'(a1);
    assign m7 = 24'(s7) * 24'(dxt_pkg::RECIP7);

    if (i < 6) begin : g_six
      localparam logic [3:0] WA5 = 4'(6 - i);
      localparam logic [3:0] WB5 = 4'(i - 1);
      logic [10:0] s5;
      logic [23:0] m5;

      assign s5     = 11'(WA5) * 11'(a0) + 11'(WB5) * 11'(a1);
      assign m5     = 24'(s5) * 24'(dxt_pkg::RECIP5);
      assign pal[i] = gt ? m7[22:15] : m5[22:15];
    end else if (i == 6) begin : g_zero
      assign pal[i] = gt ? m7[22:15] : dxt_pkg::ALPHA_CLEAR;
    end else begin : g_full
      assign pal[i] = gt ? m7[22:15] : dxt_pkg::ALPHA_OPAQUE;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dxt_emit.sv -----
// ----------------------------------------------------------------------------
// DXT texel emitter
// Merges the lane palettes into texels, one per transaction, in raster order.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt_emit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dxt_pkg::pal_t       pal,
  input  wire logic                pal_vld,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic [7:0]               out_red,
  output logic [7:0]               out_green,
  output logic [7:0]               out_blue,
  output logic [7:0]               out_alpha,
  output logic [3:0]               out_texel_index,
  output logic                     out_last_texel,
  output dxt_pkg::emit_stat_t      stat
);

  logic [3:0] cnt_r;
  logic [3:0] cnt_nxt;
  logic       vld_r;
  logic       vld_nxt;
  logic       take;
  logic       last;
  logic [1:0] ci;
  logic [2:0] ai;
  logic [7:0] alpha_sel;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;
  logic [7:0] alpha_r;
  logic [3:0] idx_r;
  logic       last_r;

  // output register free or draining this cycle
  assign take = pal_vld && (!vld_r || !out_stall);
  assign last = cnt_r == 4'(dxt_pkg::TEXELS - 1);

  assign stat.done = take && last;

  // per-texel palette selection
  assign ci        = pal.cidx[cnt_r];
  assign ai        = pal.aidx[cnt_r];
  assign alpha_sel = pal.dxt5 ? pal.alpha[ai] : dxt_pkg::ALPHA_OPAQUE;

  always_comb begin
    cnt_nxt = cnt_r;
    vld_nxt = vld_r;
    if (take) begin
      cnt_nxt = cnt_r + 4'd1;
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
    end
  end

  // texel payload
  always_ff @(posedge clk) begin
    if (take) begin
      red_r   <= pal.red[ci];
      green_r <= pal.green[ci];
      blue_r  <= pal.blue[ci];
      alpha_r <= alpha_sel;
      idx_r   <= cnt_r;
      last_r  <= last;
    end
  end

  assign out_valid       = vld_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_alpha       = alpha_r;
  assign out_texel_index = idx_r;
  assign out_last_texel  = last_r;

endmodule

`default_nettype wire

// ----- sv/dxt_block_decoder_top.sv -----
// ----------------------------------------------------------------------------
// DXT block decoder top level
// Decodes DXT1 or DXT5 4x4 blocks into sixteen texels, raster order.
// ----------------------------------------------------------------------------
// Pipeline: input block register, palette bank, then the texel output register.
// Texels leave through the single texel output port, one per transaction;
// the next block is taken while the current one's texels drain.
// Reset: pipeline valids and texel counter cleared, format set to DXT1.
`default_nettype none

module dxt_block_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_color_block,
  input  wire logic [63:0] in_alpha_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic [3:0]       out_texel_index,
  output logic             out_last_texel
);

  logic                fmt_r;
  logic                a_vld_r;
  logic                a_vld_nxt;
  logic [63:0]         a_cblk_r;
  logic [63:0]         a_ablk_r;
  logic                a_mode_r;
  logic                b_vld_r;
  logic                b_vld_nxt;
  dxt_pkg::pal_t       b_pal_r;
  dxt_pkg::pal_t       pal_nxt;
  dxt_pkg::emit_stat_t stat;
  logic                accept;
  logic                b_free;
  logic                move_ab;
  logic                four;
  logic [15:0]         c0;
  logic [15:0]         c1;
  logic [2:0][7:0]     e0;
  logic [2:0][7:0]     e1;
  logic [2:0][7:0]     p2;
  logic [2:0][7:0]     p3;
  logic [7:0][7:0]     apal;

  // format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= dxt_pkg::FMT_DXT1;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_wr_data;
    end
  end

  // pipeline handshake
  assign b_free   = !b_vld_r || stat.done;
  assign move_ab  = a_vld_r && b_free;
  assign in_stall = a_vld_r && !b_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    a_vld_nxt = a_vld_r;
    if (accept) begin
      a_vld_nxt = 1'b1;
    end else if (move_ab) begin
      a_vld_nxt = 1'b0;
    end
    b_vld_nxt = b_vld_r;
    if (move_ab) begin
      b_vld_nxt = 1'b1;
    end else if (stat.done) begin
      b_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
    end
  end

  // input block register
  always_ff @(posedge clk) begin
    if (accept) begin
      a_cblk_r <= in_color_block;
      a_ablk_r <= in_alpha_block;
      a_mode_r <= fmt_r;
    end
  end

  // endpoint widening: lane 0 red, 1 green, 2 blue
  assign c0    = a_cblk_r[15:0];
  assign c1    = a_cblk_r[31:16];
  assign four  = (a_mode_r == dxt_pkg::FMT_DXT5) || (c0 > c1);
  assign e0[0] = dxt_pkg::WIDEN5[c0[15:11]];
  assign e0[1] = dxt_pkg::WIDEN6[c0[10:5]];
  assign e0[2] = dxt_pkg::WIDEN5[c0[4:0]];
  assign e1[0] = dxt_pkg::WIDEN5[c1[15:11]];
  assign e1[1] = dxt_pkg::WIDEN6[c1[10:5]];
  assign e1[2] = dxt_pkg::WIDEN5[c1[4:0]];

  // colour lanes
  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    dxt_color_lane u_lane (
      .e0   (e0[ch]),
      .e1   (e1[ch]),
      .four (four),
      .p2   (p2[ch]),
      .p3   (p3[ch])
    );
  end

  // alpha lane
  dxt_alpha_lane u_alpha (
    .a0  (a_ablk_r[7:0]),
    .a1  (a_ablk_r[15:8]),
    .pal (apal)
  );

  // collect lane results into the palette bank
  always_comb begin
    pal_nxt.red   = {p3[0], p2[0], e1[0], e0[0]};
    pal_nxt.green = {p3[1], p2[1], e1[1], e0[1]};
    pal_nxt.blue  = {p3[2], p2[2], e1[2], e0[2]};
    pal_nxt.alpha = apal;
    pal_nxt.cidx  = a_cblk_r[63:32];
    pal_nxt.aidx  = a_ablk_r[63:16];
    pal_nxt.dxt5  = a_mode_r == dxt_pkg::FMT_DXT5;
  end

  always_ff @(posedge clk) begin
    if (move_ab) begin
      b_pal_r <= pal_nxt;
    end
  end

  // texel emitter
  dxt_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .pal             (b_pal_r),
    .pal_vld         (b_vld_r),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_texel_index (out_texel_index),
    .out_last_texel  (out_last_texel),
    .stat            (stat)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// DXT block decoder testbench
// Feeds DXT1 and DXT5 blocks under random idle and stall. A built-in
// decoder predicts the sixteen texels of each block, and a scoreboard
// compares them field by field with the decoded output.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // one decoded texel, field order as on the output port
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] texel_index;
    logic       last_texel;
  } texel_t;

  // Predicts the texels of each accepted block and checks decoded output
  class texel_scoreboard;
    texel_t expected_texels[$];
    logic   fmt;
    int     mismatch_count;

    function new();
      fmt = dxt_pkg::FMT_DXT1;
      mismatch_count = 0;
    endfunction

    function int pending();
      return expected_texels.size();
    endfunction

    task report(string msg);
      if (mismatch_count < 40)
        $display("ERROR %0t ns: %s", $time, msg);
      mismatch_count++;
    endtask

    // 5- or 6-bit endpoint channel widened to 8 bits, truncated
    function logic [7:0] widen(int unsigned v, int unsigned full_scale);
      return 8'((v * 255) / full_scale);
    endfunction

    // decode one block into sixteen expected texels
    function void note_block(logic [63:0] cb, logic [63:0] ab);
      logic [15:0]  c0;
      logic [15:0]  c1;
      logic [7:0]   rgb[4][3];
      logic [7:0]   apal[8];
      logic         four_colour;
      int unsigned  a;
      int unsigned  b;
      logic [1:0]   ci;
      texel_t       t;
      c0 = cb[15:0];
      c1 = cb[31:16];
      four_colour = (fmt == dxt_pkg::FMT_DXT5) || (c0 > c1);
      rgb[0][0] = widen(c0[15:11], 31);
      rgb[0][1] = widen(c0[10:5], 63);
      rgb[0][2] = widen(c0[4:0], 31);
      rgb[1][0] = widen(c1[15:11], 31);
      rgb[1][1] = widen(c1[10:5], 63);
      rgb[1][2] = widen(c1[4:0], 31);
      for (int ch = 0; ch < 3; ch++) begin
        a = rgb[0][ch];
        b = rgb[1][ch];
        if (four_colour) begin
          rgb[2][ch] = 8'((2 * a + b) / 3);
          rgb[3][ch] = 8'((a + 2 * b) / 3);
        end else begin
          rgb[2][ch] = 8'((a + b) / 2);
          rgb[3][ch] = 8'd0;  // black entry
        end
      end
      // alpha palette: eight-entry or six-entry with clear/opaque
      a = ab[7:0];
      b = ab[15:8];
      apal[0] = ab[7:0];
      apal[1] = ab[15:8];
      if (a > b) begin
        for (int unsigned i = 2; i < 8; i++)
          apal[i] = 8'(((8 - i) * a + (i - 1) * b) / 7);
      end else begin
        for (int unsigned i = 2; i < 6; i++)
          apal[i] = 8'(((6 - i) * a + (i - 1) * b) / 5);
        apal[6] = dxt_pkg::ALPHA_CLEAR;
        apal[7] = dxt_pkg::ALPHA_OPAQUE;
      end
      for (int i = 0; i < dxt_pkg::TEXELS; i++) begin
        ci = cb[32 + 2 * i +: 2];
        t.red   = rgb[ci][0];
        t.green = rgb[ci][1];
        t.blue  = rgb[ci][2];
        t.alpha = (fmt == dxt_pkg::FMT_DXT5) ? apal[ab[16 + 3 * i +: 3]]
                                             : dxt_pkg::ALPHA_OPAQUE;
        t.texel_index = 4'(i);
        t.last_texel  = (i == dxt_pkg::TEXELS - 1);
        expected_texels.insert(expected_texels.size(), t);
      end
    endfunction

    task compare_field(string name, logic [7:0] got, logic [7:0] want, int idx);
      if (got !== want)
        report($sformatf("texel %0d %s: got %0h, expected %0h", idx, name, got, want));
    endtask

    // check one decoded texel against the oldest expectation
    task check_texel(texel_t got);
      texel_t want;
      if (expected_texels.size() == 0) begin
        report($sformatf("unexpected texel, index %0d", got.texel_index));
        return;
      end
      want = expected_texels.pop_front();
      compare_field("red", got.red, want.red, want.texel_index);
      compare_field("green", got.green, want.green, want.texel_index);
      compare_field("blue", got.blue, want.blue, want.texel_index);
      compare_field("alpha", got.alpha, want.alpha, want.texel_index);
      compare_field("texel_index", 8'(got.texel_index), 8'(want.texel_index),
                    want.texel_index);
      compare_field("last_texel", 8'(got.last_texel), 8'(want.last_texel),
                    want.texel_index);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_color_block = '0;
  logic [63:0] in_alpha_block = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [3:0]  out_texel_index;
  logic        out_last_texel;

  int send_idle_pct = 33;
  int stall_pct = 33;
  int hold_cycles = 0;

  texel_scoreboard sb = new();

  dxt_block_decoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_color_block  (in_color_block),
    .in_alpha_block  (in_alpha_block),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_texel_index (out_texel_index),
    .out_last_texel  (out_last_texel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit idle_roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= idle_roll(stall_pct);
    end
  end

  // texel monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      sb.check_texel(texel_t'({out_red, out_green, out_blue, out_alpha,
                               out_texel_index, out_last_texel}));
  end

  // offer one block, with a random gap first; returns at its transaction
  task automatic send_block(logic [63:0] cb, logic [63:0] ab);
    @(negedge clk);
    while (idle_roll(send_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_color_block <= cb;
    in_alpha_block <= ab;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_block(cb, ab);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // format write once the decoder has drained
  task automatic write_format(logic m);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.fmt = m;
  endtask

  // alpha half with the given endpoints and indices 0..7 twice over
  function automatic logic [63:0] alpha_ramp(logic [7:0] a0, logic [7:0] a1);
    logic [63:0] ab;
    ab = {48'd0, a1, a0};
    for (int i = 0; i < dxt_pkg::TEXELS; i++) ab[16 + 3 * i +: 3] = 3'(i);
    return ab;
  endfunction

  // random block, sometimes steered onto endpoint edge cases
  task automatic send_random_block();
    logic [63:0] cb;
    logic [63:0] ab;
    cb = {$urandom, $urandom};
    ab = {$urandom, $urandom};
    case ($urandom_range(9, 0))
      0: cb[31:16] = cb[15:0];
      1: ab[15:8] = ab[7:0];
      2: cb[31:0] = {16'h0000, 16'hffff};
      3: cb[31:0] = {16'hffff, 16'h0000};
      4: ab[15:0] = {8'h00, 8'hff};
      5: ab[15:0] = {8'hff, 8'h00};
      default: ;
    endcase
    send_block(cb, ab);
  endtask

  task automatic run_random(int count);
    repeat (count) send_random_block();
    stop_sending();
  endtask

  // Limit on the whole run
  initial begin
    #2_000_000;
    $display("** dxt_block_decoder_top: FAILED **");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // DXT1 directed: colour mode choice, black entry, ignored alpha half
    write_format(dxt_pkg::FMT_DXT1);
    send_block({32'he4e4e4e4, 16'h0000, 16'hffff}, 64'd0);
    send_block({32'he4e4e4e4, 16'hffff, 16'h0000}, 64'd0);
    send_block({32'he4e4e4e4, 16'h1234, 16'h1234}, 64'hffff_ffff_ffff_ffff);
    send_block(64'd0, 64'd0);
    send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_block({32'h1b1b1b1b, 16'h07e0, 16'hf800}, alpha_ramp(8'hff, 8'h00));
    send_block({32'he4e4e4e4, 16'hf800, 16'h001f}, 64'd0);
    send_block({32'he4e4e4e4, 16'h0000, 16'h0001}, 64'd0);
    stop_sending();

    // DXT5 directed: four-colour always, both alpha palette kinds
    write_format(dxt_pkg::FMT_DXT5);
    send_block({32'he4e4e4e4, 16'hffff, 16'h0000}, alpha_ramp(8'hff, 8'h00));
    send_block({32'he4e4e4e4, 16'h0000, 16'hffff}, alpha_ramp(8'h00, 8'hff));
    send_block({32'h1b1b1b1b, 16'h1234, 16'h1234}, alpha_ramp(8'h80, 8'h80));
    send_block({32'he4e4e4e4, 16'hf800, 16'h07e0}, alpha_ramp(8'h00, 8'h00));
    send_block({32'he4e4e4e4, 16'h001f, 16'hf800}, alpha_ramp(8'hff, 8'hff));
    send_block({32'he4e4e4e4, 16'h0000, 16'h0001}, alpha_ramp(8'h01, 8'h00));
    send_block({32'he4e4e4e4, 16'h8000, 16'h7fff}, alpha_ramp(8'h00, 8'h01));
    send_block(64'd0, 64'd0);
    send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    stop_sending();

    // DXT1 random, back to back on both sides
    write_format(dxt_pkg::FMT_DXT1);
    send_idle_pct = 0;
    stall_pct = 0;
    run_random(26);
    send_idle_pct = 33;
    stall_pct = 33;

    // DXT5 random, opening with a long receiver hold-off
    write_format(dxt_pkg::FMT_DXT5);
    @(posedge clk);
    hold_cycles = 80;
    run_random(26);

    write_format(dxt_pkg::FMT_DXT1);
    run_random(26);

    write_format(dxt_pkg::FMT_DXT5);
    run_random(26);

    // drain, then watch for stray texels
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0)
      $display("** dxt_block_decoder_top: PASSED **");
    else
      $display("** dxt_block_decoder_top: FAILED **");
    $finish;
  end

endmodule
